[rtl/core/cbb_pkg.sv]
// ----------------------------------------------------------------------------
// cbb_pkg
// shared constants, types and command structs of the cascaded biquad bandpass
// ----------------------------------------------------------------------------
package cbb_pkg;

    // chain size and number format
    localparam int STAGES     = 8;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int COEF_IDX_W = 4;

    localparam int NCOEF   = 2 * STAGES;
    localparam int COEF_AW = $clog2(NCOEF);
    localparam int STAGE_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int TAP_W   = 3;
    localparam int PROD_W  = 2 * DATA_W;

    // last tap of the first stage (three scaled taps, two feedback) and of the others
    localparam logic [TAP_W-1:0] LAST_TAP_FIRST = TAP_W'(4);
    localparam logic [TAP_W-1:0] LAST_TAP_OTHER = TAP_W'(1);

    localparam logic signed [DATA_W-1:0] SCALE_RESET = DATA_W'(65536);

    // action codes
    localparam logic ACTION_FILTER = 1'b0;
    localparam logic ACTION_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN
    } t_state;

    // multiplier operand selection
    typedef enum logic [2:0] {
        OP_X0,
        OP_X1,
        OP_X2,
        OP_A1,
        OP_A2
    } t_mul_op;

    typedef struct packed {
        logic               sample_load;
        logic               coef_load;
        logic               mul_en;
        t_mul_op            mul_op;
        logic               acc_init;
        logic               commit;
        logic               out_load;
        logic [STAGE_W-1:0] stage;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_stat;

endpackage

[rtl/core/cbb_ctrl.sv]
// ----------------------------------------------------------------------------
// cbb_ctrl
// sequencer: walks stages and taps, issues datapath commands
// ----------------------------------------------------------------------------
module cbb_ctrl
    import cbb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_action,
    output logic    o_busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd o_cmd
);

    t_state             r_state, n_state;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic [TAP_W-1:0]   r_tap, n_tap;

    logic               w_first;
    logic               w_last_stage;
    logic [TAP_W-1:0]   w_last_tap;

    assign w_first      = (r_stage == '0);
    assign w_last_stage = (r_stage == STAGE_W'(STAGES - 1));
    assign w_last_tap   = w_first ? LAST_TAP_FIRST : LAST_TAP_OTHER;
    assign o_busy       = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stage <= '0;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
            r_tap   <= n_tap;
        end
    end

    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        n_tap   = r_tap;

        o_cmd             = '0;
        o_cmd.mul_op      = OP_X0;
        o_cmd.stage       = r_stage;

        // tap to operand map
        if (w_first) begin
            case (r_tap)
                TAP_W'(0): o_cmd.mul_op = OP_X0;
                TAP_W'(1): o_cmd.mul_op = OP_X1;
                TAP_W'(2): o_cmd.mul_op = OP_X2;
                TAP_W'(3): o_cmd.mul_op = OP_A1;
                default:   o_cmd.mul_op = OP_A2;
            endcase
        end else begin
            o_cmd.mul_op = (r_tap == '0) ? OP_A1 : OP_A2;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_action == ACTION_COEF) begin
                        o_cmd.coef_load = 1'b1;
                    end else begin
                        o_cmd.sample_load = 1'b1;
                        n_state = ST_MUL;
                        n_stage = '0;
                        n_tap   = '0;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.acc_init = (r_tap == '0);
                if (r_tap == w_last_tap) begin
                    n_state = ST_FIN;
                end else begin
                    n_tap = r_tap + TAP_W'(1);
                end
            end
            ST_FIN: begin
                if (w_last_stage) begin
                    if (!i_stat.out_full) begin
                        o_cmd.commit   = 1'b1;
                        o_cmd.out_load = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_cmd.commit = 1'b1;
                    n_stage = r_stage + STAGE_W'(1);
                    n_tap   = '0;
                    n_state = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/cbb_datapath.sv]
// ----------------------------------------------------------------------------
// cbb_datapath
// histories, coefficient table, shared multiplier, accumulator, output register
// ----------------------------------------------------------------------------
module cbb_datapath
    import cbb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic                     i_cfg_wr_en,
    input  logic signed [DATA_W-1:0] i_cfg_wr_data,
    input  logic signed [DATA_W-1:0] i_sample_in,
    input  logic [COEF_IDX_W-1:0]    i_coef_index,
    input  logic signed [DATA_W-1:0] i_coef_value,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_filtered_out
);

    logic signed [DATA_W-1:0] r_scale;
    logic signed [DATA_W-1:0] r_x    [3];
    logic signed [DATA_W-1:0] r_hist [STAGES][3];
    logic signed [DATA_W-1:0] r_prev [3];
    logic signed [DATA_W-1:0] r_coef [NCOEF];
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_psub;
    logic signed [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] r_out;
    logic                     r_ov;

    logic signed [DATA_W-1:0] w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [DATA_W-1:0] w_pslice, w_pterm, w_sum;
    logic signed [DATA_W-1:0] w_t0, w_t1, w_t2, w_num;
    logic [COEF_AW-1:0]       w_a1_idx, w_a2_idx, w_wr_idx;

    assign w_a1_idx = {i_cmd.stage, 1'b0};
    assign w_a2_idx = {i_cmd.stage, 1'b1};
    assign w_wr_idx = COEF_AW'(i_coef_index);

    // operand select for the shared multiplier, r_hist[0] is always the current stage
    always_comb begin
        case (i_cmd.mul_op)
            OP_X0: begin
                w_mul_a = r_x[0];
                w_mul_b = r_scale;
            end
            OP_X1: begin
                w_mul_a = {r_x[1][DATA_W-2:0], 1'b0};
                w_mul_b = r_scale;
            end
            OP_X2: begin
                w_mul_a = r_x[2];
                w_mul_b = r_scale;
            end
            OP_A1: begin
                w_mul_a = r_coef[w_a1_idx];
                w_mul_b = r_hist[0][0];
            end
            OP_A2: begin
                w_mul_a = r_coef[w_a2_idx];
                w_mul_b = r_hist[0][1];
            end
            default: begin
                w_mul_a = r_x[0];
                w_mul_b = r_scale;
            end
        endcase
    end

    assign w_prod   = w_mul_a * w_mul_b;
    assign w_pslice = r_prod[FRAC_BITS +: DATA_W];
    assign w_pterm  = r_psub ? -w_pslice : w_pslice;
    assign w_sum    = r_acc + w_pterm;

    // doubled numerator taps from the previous stage, middle tap doubled again
    assign w_t0  = {r_prev[0][DATA_W-2:0], 1'b0};
    assign w_t1  = {r_prev[1][DATA_W-3:0], 2'b00};
    assign w_t2  = {r_prev[2][DATA_W-2:0], 1'b0};
    assign w_num = i_cmd.stage[0] ? (w_t0 - w_t1 + w_t2) : (w_t0 + w_t1 + w_t2);

    assign o_stat.out_full = r_ov && i_stall;
    assign o_valid         = r_ov;
    assign o_filtered_out  = r_out;

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
            r_ov    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_x[k] <= '0;
            end
            for (int s = 0; s < STAGES; s++) begin
                for (int k = 0; k < 3; k++) begin
                    r_hist[s][k] <= '0;
                end
            end
            for (int c = 0; c < NCOEF; c++) begin
                r_coef[c] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_scale <= i_cfg_wr_data;
            end
            if (i_cmd.coef_load && (32'(i_coef_index) < NCOEF)) begin
                r_coef[w_wr_idx] <= i_coef_value;
            end
            if (i_cmd.sample_load) begin
                r_x[2] <= r_x[1];
                r_x[1] <= r_x[0];
                r_x[0] <= i_sample_in;
            end
            // rotate the stage histories so the next stage lands at index 0
            if (i_cmd.commit) begin
                for (int s = 0; s < STAGES - 1; s++) begin
                    r_hist[s] <= r_hist[s+1];
                end
                r_hist[STAGES-1][0] <= w_sum;
                r_hist[STAGES-1][1] <= r_hist[0][0];
                r_hist[STAGES-1][2] <= r_hist[0][1];
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
            r_psub <= (i_cmd.mul_op == OP_A1) || (i_cmd.mul_op == OP_A2);
            if (i_cmd.acc_init) begin
                r_acc <= (i_cmd.stage == '0) ? '0 : w_num;
            end else begin
                r_acc <= w_sum;
            end
        end
        if (i_cmd.commit) begin
            r_prev[0] <= w_sum;
            r_prev[1] <= r_hist[0][0];
            r_prev[2] <= r_hist[0][1];
        end
        if (i_cmd.out_load) begin
            r_out <= w_sum;
        end
    end

endmodule

[rtl/core/cascaded_biquad_bandpass_top.sv]
// ----------------------------------------------------------------------------
// cascaded_biquad_bandpass_top
// bandpass made of a chain of direct form i biquads with a shared multiplier
// ----------------------------------------------------------------------------
//
//  port group   dir   handshake            payload
//  in channel   in    i_valid / o_stall    i_action, i_sample_in, i_coef_index,
//                                          i_coef_value
//  out channel  out   o_valid / i_stall    o_filtered_out
//  config       in    i_cfg_wr_en          i_cfg_wr_data (filter scale)
//
//  a sample beat is taken from idle, then the single 32x32 multiplier
//  walks the chain: five products for the first stage, two for each
//  later one, plus one closing step per stage to commit its sum
//  a coefficient beat is taken from idle and gives no result
//  reset is synchronous, clears histories and coefficients, sets unity scale
//  a held result only blocks the final commit of the next sample
//
module cascaded_biquad_bandpass_top
    import cbb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_action,
    input  logic signed [DATA_W-1:0] i_sample_in,
    input  logic [COEF_IDX_W-1:0]    i_coef_index,
    input  logic signed [DATA_W-1:0] i_coef_value,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_filtered_out,
    // configuration
    input  logic                     i_cfg_wr_en,
    input  logic signed [DATA_W-1:0] i_cfg_wr_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_busy;

    // input side stalls while a sample walks the chain
    assign o_stall = w_busy;

    // sequencer: stage and tap counters
    cbb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_busy   (w_busy),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    // histories, coefficient table, multiplier and accumulator
    cbb_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample_in    (i_sample_in),
        .i_coef_index   (i_coef_index),
        .i_coef_value   (i_coef_value),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_filtered_out (o_filtered_out)
    );

    // a new result only comes from the last stage's commit
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.out_load))
        else $error("result appeared without a final commit");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_valid && i_stall))
        else $error("result overwritten while stalled");

    // an accepted sample keeps the input side stalled on the next cycle
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_action == ACTION_FILTER)) |=> o_stall)
        else $error("sample accepted but sequencer idle");

    // coefficient writes only happen between samples
    a_coef_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.coef_load |-> !w_cmd.mul_en && !w_cmd.commit)
        else $error("coefficient write during filtering");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cascaded biquad bandpass: a queue of input
// beats feeds a clocked driver, a bit-true model of the filter chain predicts
// each filtered sample at input acceptance, and a clocked monitor compares
// every output beat against the oldest prediction under random back-pressure
// ----------------------------------------------------------------------------
module tb_top;
    import cbb_pkg::*;

    // drain wait covers one full sample pass with margin
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BEATS    = 55;
    localparam int PRINT_CAP      = 20;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] sample;
        logic [COEF_IDX_W-1:0]    coef_index;
        logic signed [DATA_W-1:0] coef_value;
    } t_beat;

    // dut ports, inputs all known from time zero
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_valid        = 1'b0;
    logic                     o_stall;
    logic                     i_action       = ACTION_FILTER;
    logic signed [DATA_W-1:0] i_sample_in    = '0;
    logic [COEF_IDX_W-1:0]    i_coef_index   = '0;
    logic signed [DATA_W-1:0] i_coef_value   = '0;
    logic                     o_valid;
    logic                     i_stall        = 1'b0;
    logic signed [DATA_W-1:0] o_filtered_out;
    logic                     i_cfg_wr_en    = 1'b0;
    logic signed [DATA_W-1:0] i_cfg_wr_data  = '0;

    // filter model state
    logic signed [DATA_W-1:0] scale_model;
    logic signed [DATA_W-1:0] x_hist [3];
    logic signed [DATA_W-1:0] y_hist [STAGES][3];
    logic signed [DATA_W-1:0] fb_coef [NCOEF];

    // beats waiting to be driven and filtered samples still owed by the dut
    t_beat                    pending_beats [$];
    logic signed [DATA_W-1:0] predicted_outputs [$];

    t_beat                    drive_beat;
    logic                     in_flight    = 1'b0;
    logic                     idle_mode    = 1'b0;
    int                       gap_left     = 0;
    int                       stall_left   = 0;
    int                       quiet_cycles = 0;
    int                       mismatch_count = 0;
    logic signed [DATA_W-1:0] want;

    cascaded_biquad_bandpass_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_sample_in    (i_sample_in),
        .i_coef_index   (i_coef_index),
        .i_coef_value   (i_coef_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_filtered_out (o_filtered_out),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // filter model
    // ------------------------------------------------------------------

    // fixed-point product: full signed product, arithmetic shift, wrap
    function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        logic signed [PROD_W-1:0] p;
        p = a * b;
        return DATA_W'(p >>> FRAC_BITS);
    endfunction

    task automatic clear_model();
        scale_model = SCALE_RESET;
        foreach (x_hist[k]) x_hist[k] = '0;
        foreach (y_hist[s, k]) y_hist[s][k] = '0;
        foreach (fb_coef[k]) fb_coef[k] = '0;
    endtask

    // apply one accepted beat: coefficient load or one pass through the chain
    task automatic advance_filter(input t_beat b);
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] t0;
        logic signed [DATA_W-1:0] t1;
        logic signed [DATA_W-1:0] t2;
        if (b.action == ACTION_COEF) begin
            // slots past the chain are dropped
            if (int'(b.coef_index) < NCOEF)
                fb_coef[b.coef_index] = b.coef_value;
        end else begin
            x_hist[2] = x_hist[1];
            x_hist[1] = x_hist[0];
            x_hist[0] = b.sample;
            // first stage: scaled taps, +2 middle tap
            t1  = x_hist[1] << 1;
            acc = fx_mul(x_hist[0], scale_model) + fx_mul(t1, scale_model)
                + fx_mul(x_hist[2], scale_model);
            acc = acc - fx_mul(fb_coef[0], y_hist[0][0]) - fx_mul(fb_coef[1], y_hist[0][1]);
            y_hist[0][2] = y_hist[0][1];
            y_hist[0][1] = y_hist[0][0];
            y_hist[0][0] = acc;
            // later stages: doubled taps, middle tap sign alternates
            for (int s = 1; s < STAGES; s++) begin
                t0  = y_hist[s-1][0] << 1;
                t1  = y_hist[s-1][1] << 2;
                t2  = y_hist[s-1][2] << 1;
                acc = (s % 2 == 1) ? (t0 - t1 + t2) : (t0 + t1 + t2);
                acc = acc - fx_mul(fb_coef[2*s], y_hist[s][0])
                          - fx_mul(fb_coef[2*s+1], y_hist[s][1]);
                y_hist[s][2] = y_hist[s][1];
                y_hist[s][1] = y_hist[s][0];
                y_hist[s][0] = acc;
            end
            predicted_outputs.push_back(y_hist[STAGES-1][0]);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // no gap outside idle mode; else half back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return pick_extreme();
            1, 2:    return DATA_W'(int'($urandom_range(0, 4000)) - 2000);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // moderate values stay within about +-2.0 in q16
    function automatic logic signed [DATA_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:          return pick_extreme();
            1, 2, 3:    return DATA_W'(int'($urandom_range(0, 262144)) - 131072);
            default:    return DATA_W'($urandom);
        endcase
    endfunction

    // unused fields carry random content so that the dut must ignore them
    function automatic t_beat filter_beat(input logic signed [DATA_W-1:0] v);
        t_beat b;
        b.action     = ACTION_FILTER;
        b.sample     = v;
        b.coef_index = COEF_IDX_W'($urandom);
        b.coef_value = DATA_W'($urandom);
        return b;
    endfunction

    function automatic t_beat coef_beat(input logic [COEF_IDX_W-1:0] idx,
                                        input logic signed [DATA_W-1:0] v);
        t_beat b;
        b.action     = ACTION_COEF;
        b.sample     = DATA_W'($urandom);
        b.coef_index = idx;
        b.coef_value = v;
        return b;
    endfunction

    // one random run: usually coefficient loads then a burst of samples,
    // sometimes a handful of fully random beats
    function automatic int add_sequence();
        t_beat b;
        int    n;
        int    count;
        count = 0;
        if ($urandom_range(0, 9) < 8) begin
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++) begin
                pending_beats.push_back(coef_beat(COEF_IDX_W'($urandom), pick_coef()));
                count++;
            end
            n = $urandom_range(3, 12);
            for (int k = 0; k < n; k++) begin
                pending_beats.push_back(filter_beat(pick_sample()));
                count++;
            end
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                b = t_beat'({$urandom, $urandom, $urandom});
                pending_beats.push_back(b);
                count++;
            end
        end
        return count;
    endfunction

    // extremes of each field, both actions, top and bottom slots
    task automatic load_directed();
        pending_beats.push_back(filter_beat(DATA_W'(1)));
        pending_beats.push_back(filter_beat('0));
        pending_beats.push_back(filter_beat({1'b0, {(DATA_W-1){1'b1}}}));
        pending_beats.push_back(filter_beat({1'b1, {(DATA_W-1){1'b0}}}));
        pending_beats.push_back(filter_beat('1));
        pending_beats.push_back(coef_beat(4'd0, {1'b0, {(DATA_W-1){1'b1}}}));
        pending_beats.push_back(coef_beat(4'd1, {1'b1, {(DATA_W-1){1'b0}}}));
        pending_beats.push_back(coef_beat(4'd15, '1));
        pending_beats.push_back(coef_beat(4'd14, DATA_W'(65536)));
        pending_beats.push_back(filter_beat({1'b1, {(DATA_W-1){1'b0}}}));
        pending_beats.push_back(filter_beat({1'b0, {(DATA_W-1){1'b1}}}));
        pending_beats.push_back(filter_beat('0));
        pending_beats.push_back(coef_beat(4'd7, DATA_W'(32768)));
        pending_beats.push_back(filter_beat(DATA_W'(-12345)));
        pending_beats.push_back(coef_beat(4'd0, '0));
        pending_beats.push_back(coef_beat(4'd1, '0));
        pending_beats.push_back(coef_beat(4'd14, '0));
        pending_beats.push_back(coef_beat(4'd15, '0));
        pending_beats.push_back(filter_beat(DATA_W'(1000)));
        pending_beats.push_back(filter_beat('0));
    endtask

    // wait until every beat is in and every output is out, then let the
    // datapath settle in case the last beat was a coefficient load
    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_flight || predicted_outputs.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // scale register write, only called with the dut idle
    task automatic write_scale(input logic signed [DATA_W-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        scale_model = v;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic signed [DATA_W-1:0] scale_plan [7];
        int                       added;
        // full-scale, most negative, zero, unity negated, a quarter, random, lsb
        scale_plan[0] = {1'b0, {(DATA_W-1){1'b1}}};
        scale_plan[1] = {1'b1, {(DATA_W-1){1'b0}}};
        scale_plan[2] = '0;
        scale_plan[3] = DATA_W'(-65536);
        scale_plan[4] = DATA_W'(16384);
        scale_plan[5] = DATA_W'($urandom);
        scale_plan[6] = DATA_W'(1);
        clear_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats at the reset scale, no idling
        load_directed();
        wait_drained();

        // random phases, one scale each; phase 2 runs with no idling
        for (int ph = 0; ph < 7; ph++) begin
            write_scale(scale_plan[ph]);
            idle_mode = (ph != 2);
            added = 0;
            while (added < PHASE_BEATS)
                added += add_sequence();
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // input driver: model update on acceptance, then next beat or a gap
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                advance_filter(drive_beat);
                in_flight = 1'b0;
            end
            // a stalled beat stays put
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    drive_beat = pending_beats.pop_front();
                    in_flight  = 1'b1;
                    i_action     <= drive_beat.action;
                    i_sample_in  <= drive_beat.sample;
                    i_coef_index <= drive_beat.coef_index;
                    i_coef_value <= drive_beat.coef_value;
                    i_valid      <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor and receiver back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_outputs.size() == 0) begin
                if (mismatch_count < PRINT_CAP)
                    $display("%0t: unexpected output beat, actual %0d", $time, o_filtered_out);
                mismatch_count++;
            end else begin
                want = predicted_outputs.pop_front();
                if (o_filtered_out !== want) begin
                    if (mismatch_count < PRINT_CAP)
                        $display("%0t: filtered_out mismatch, expected %0d actual %0d",
                                 $time, want, o_filtered_out);
                    mismatch_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (idle_mode && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no beat moving on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

endmodule

[files.f]
rtl/core/cbb_pkg.sv
rtl/core/cbb_ctrl.sv
rtl/core/cbb_datapath.sv
rtl/core/cascaded_biquad_bandpass_top.sv
bench/tb_top.sv
